// ===== hdl/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants for the sensor range gate
// Field widths, force factors, sequencer states and controller commands.
// ----------------------------------------------------------------------------
package srg_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned RMS_W     = 31;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned K_W       = 23;
  localparam int unsigned PROD_W    = SAMPLE_W + K_W;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(1048576);

  // signed q7.16 force factors
  localparam logic signed [K_W-1:0] K_HEAD = K_W'(2217562);
  localparam logic signed [K_W-1:0] K_ROD  = K_W'(1537335);

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = CFG_IDX_W'(2);

  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  localparam int unsigned ITER_W     = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_COND,
    ST_SQ,
    ST_ACC,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MULA,
    CMD_MULB,
    CMD_COND,
    CMD_SQ,
    CMD_ACC,
    CMD_DIV,
    CMD_SQRT,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

// ===== hdl/srg_if.sv =====
// ----------------------------------------------------------------------------
// srg_if: sample and result channels
// Valid/ready channels carrying one sample record or one result record a beat.
// ----------------------------------------------------------------------------
interface srg_in_if import srg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_a;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic                       last_sample;

  modport source (output valid, sample_a, sample_b, last_sample, input ready);
  modport sink   (input valid, sample_a, sample_b, last_sample, output ready);
endinterface

interface srg_out_if import srg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       run_done;
  logic signed [SAMPLE_W-1:0] run_minimum;
  logic signed [SAMPLE_W-1:0] run_maximum;
  logic        [RMS_W-1:0]    run_rms;
  logic        [COUNT_W-1:0]  run_count;

  modport source (output valid, sample_value, run_done, run_minimum, run_maximum,
                  run_rms, run_count, input ready);
  modport sink   (input valid, sample_value, run_done, run_minimum, run_maximum,
                  run_rms, run_count, output ready);
endinterface

// ===== hdl/sensor_range_gate_min_max_rms.sv =====
// ----------------------------------------------------------------------------
// sensor_range_gate_min_max_rms: range-gated sample conditioner with statistics
// Takes one sample record a beat on in_ch and returns one result beat on
// out_ch with the conditioned value, run_done and run min, max, rms, count.
// Registers mode, min_value and max_value are written through cfg_we,
// cfg_index and cfg_data, by the user only while the block is idle; the
// block itself does not enforce this. Records are taken one at a time: a
// new record is accepted only after the previous result is written. A
// record marked last also runs the 64-step restoring divide and the
// 32-step integer root, which share one 64-bit shift register.
// Reset: synchronous, active low; the run is cleared, mode is plain and the
// range is the full signed span.
// Stall: the result register holds its beat while out_ch.ready is low; the
// next record may be accepted and worked on, and waits before its result
// is written until the held beat is taken.
// ----------------------------------------------------------------------------
module sensor_range_gate_min_max_rms import srg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  srg_in_if.sink               in_ch,
  srg_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample_a      (in_ch.sample_a),
    .in_sample_b      (in_ch.sample_b),
    .in_last_sample   (in_ch.last_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_sample_value (out_ch.sample_value),
    .out_run_done     (out_ch.run_done),
    .out_run_minimum  (out_ch.run_minimum),
    .out_run_maximum  (out_ch.run_maximum),
    .out_run_rms      (out_ch.run_rms),
    .out_run_count    (out_ch.run_count)
  );

endmodule

// ===== hdl/srg_ctrl.sv =====
// ----------------------------------------------------------------------------
// srg_ctrl: sequencer for the sensor range gate
// Steps one sample through multiply, gate, square, accumulate and, on the
// last sample of a run, the divide and root iterations; owns the beat flags.
// ----------------------------------------------------------------------------
module srg_ctrl import srg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op        = CMD_NONE;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd.op    = CMD_MULA;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        cmd.op    = CMD_MULB;
        state_nxt = ST_COND;
      end
      ST_COND: begin
        cmd.op    = CMD_COND;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.op    = CMD_SQ;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = CMD_ACC;
        iter_nxt  = '0;
        state_nxt = stat.last ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.op = CMD_DIV;
        if (iter_r == DIV_LAST) begin
          iter_nxt  = '0;
          state_nxt = ST_SQRT;
        end else begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      ST_SQRT: begin
        cmd.op = CMD_SQRT;
        if (iter_r == SQRT_LAST) begin
          iter_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          iter_nxt = iter_r + ITER_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = CMD_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/srg_dp.sv =====
// ----------------------------------------------------------------------------
// srg_dp: datapath for the sensor range gate
// Configuration registers, force scaling, range gate, running statistics,
// shared shift register for the restoring divide and the integer root, and
// the result register.
// ----------------------------------------------------------------------------
module srg_dp import srg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [SAMPLE_W-1:0] in_sample_a,
  input  logic signed [SAMPLE_W-1:0] in_sample_b,
  input  logic                       in_last_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data,
  output logic signed [SAMPLE_W-1:0] out_sample_value,
  output logic                       out_run_done,
  output logic signed [SAMPLE_W-1:0] out_run_minimum,
  output logic signed [SAMPLE_W-1:0] out_run_maximum,
  output logic [RMS_W-1:0]           out_run_rms,
  output logic [COUNT_W-1:0]         out_run_count
);

  localparam int unsigned DIFF_W = PROD_W + 1;
  localparam int unsigned RND_W  = DIFF_W - 16;

  logic                       mode_r;
  logic signed [SAMPLE_W-1:0] min_value_r, max_value_r;

  logic signed [SAMPLE_W-1:0] a_r, b_r;
  logic                       last_r;
  logic signed [PROD_W-1:0]   prod_a_r, prod_b_r;
  logic signed [SAMPLE_W-1:0] v_r;
  logic [SUM_W-1:0]           sq_r;

  logic signed [SAMPLE_W-1:0] min_so_far_r, max_so_far_r;
  logic [SUM_W-1:0]           square_sum_r;
  logic [COUNT_W-1:0]         counter_r;

  logic [SUM_W-1:0]           dq_r, res_r, bit_r;
  logic [COUNT_W-1:0]         rem_r;

  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag, rnd;
  logic [RND_W-1:0]           shifted;
  logic signed [SAMPLE_W-1:0] force_v, pre_v, gated_v;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           sum_nxt;
  logic [COUNT_W:0]           div_t;
  logic                       div_ge;
  logic [SUM_W-1:0]           trial;

  // force magnitude, rounded half up and saturated; mode select and range gate
  always_comb begin
    diff    = DIFF_W'(prod_a_r) - DIFF_W'(prod_b_r);
    mag     = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
    rnd     = mag + DIFF_W'(32768);
    shifted = rnd[DIFF_W-1:16];
    if (|shifted[RND_W-1:SAMPLE_W-1]) begin
      force_v = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      force_v = {1'b0, shifted[SAMPLE_W-2:0]};
    end
    pre_v = mode_r ? force_v : a_r;
    if (pre_v < min_value_r || pre_v > max_value_r) begin
      gated_v = '0;
    end else begin
      gated_v = pre_v;
    end
  end

  always_comb begin
    sum_add = {1'b0, square_sum_r} + {1'b0, sq_r};
    if (counter_r == '0) begin
      sum_nxt = sq_r;
    end else if (sum_add[SUM_W]) begin
      sum_nxt = '1;
    end else begin
      sum_nxt = sum_add[SUM_W-1:0];
    end
    div_t  = {rem_r, dq_r[SUM_W-1]};
    div_ge = div_t >= {1'b0, counter_r};
    trial  = res_r + bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      min_value_r <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      max_value_r <= {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r      <= cfg_data[0];
        CFG_MIN:  min_value_r <= cfg_data;
        CFG_MAX:  max_value_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_so_far_r <= '0;
      max_so_far_r <= '0;
      square_sum_r <= '0;
      counter_r    <= '0;
    end else begin
      case (cmd.op)
        CMD_ACC: begin
          square_sum_r <= sum_nxt;
          if (counter_r == '0) begin
            min_so_far_r <= v_r;
            max_so_far_r <= v_r;
          end else begin
            if (v_r < min_so_far_r) min_so_far_r <= v_r;
            if (v_r > max_so_far_r) max_so_far_r <= v_r;
          end
          if (counter_r < MAX_SAMPLES) counter_r <= counter_r + COUNT_W'(1);
        end
        CMD_EMIT: begin
          if (last_r) begin
            min_so_far_r <= '0;
            max_so_far_r <= '0;
            square_sum_r <= '0;
            counter_r    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        a_r    <= in_sample_a;
        b_r    <= in_sample_b;
        last_r <= in_last_sample;
      end
      CMD_MULA: prod_a_r <= PROD_W'(a_r) * PROD_W'(K_HEAD);
      CMD_MULB: prod_b_r <= PROD_W'(b_r) * PROD_W'(K_ROD);
      CMD_COND: v_r      <= gated_v;
      CMD_SQ:   sq_r     <= $unsigned(SUM_W'(v_r) * SUM_W'(v_r));
      CMD_ACC: begin
        dq_r  <= sum_nxt;
        rem_r <= '0;
        res_r <= '0;
        bit_r <= SUM_W'(1) << (SUM_W - 2);
      end
      CMD_DIV: begin
        rem_r <= div_ge ? COUNT_W'(div_t - {1'b0, counter_r}) : div_t[COUNT_W-1:0];
        dq_r  <= {dq_r[SUM_W-2:0], div_ge};
      end
      CMD_SQRT: begin
        if (dq_r >= trial) begin
          dq_r  <= dq_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      CMD_EMIT: begin
        out_sample_value <= v_r;
        out_run_done     <= last_r;
        out_run_minimum  <= min_so_far_r;
        out_run_maximum  <= max_so_far_r;
        out_run_count    <= counter_r;
        if (!last_r) begin
          out_run_rms <= '0;
        end else if (|res_r[SUM_W-1:RMS_W]) begin
          out_run_rms <= '1;
        end else begin
          out_run_rms <= res_r[RMS_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.last = last_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sample conditioner and run statistics check
// Sample records are queued by the stimulus thread and sent by a driver with
// random gaps; the result channel is stalled at random. Every accepted record
// runs through a local model of the force scaling, range gate and min / max /
// rms tracking, and each result beat is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import srg_pkg::*;

  localparam logic signed [63:0]         HEAD_FACTOR    = 64'sd2217562;
  localparam logic signed [63:0]         ROD_FACTOR     = 64'sd1537335;
  localparam logic signed [SAMPLE_W-1:0] S_MIN          = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX          = 32'sh7FFF_FFFF;
  localparam int                         WATCHDOG_LIMIT = 4000;
  localparam int                         DRAIN_CYCLES   = 120;
  localparam int                         PHASE_ITEMS    = 75;
  localparam int                         RANDOM_PHASES  = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       last;
  } sample_rec_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       done;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic        [RMS_W-1:0]    rms;
    logic        [COUNT_W-1:0]  count;
  } stats_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;

  srg_in_if  in_if ();
  srg_out_if out_if ();

  sensor_range_gate_min_max_rms dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model copy of the registers and of the run
  logic                       cur_mode;
  logic signed [SAMPLE_W-1:0] cur_min;
  logic signed [SAMPLE_W-1:0] cur_max;
  logic signed [SAMPLE_W-1:0] run_lo;
  logic signed [SAMPLE_W-1:0] run_hi;
  logic        [SUM_W-1:0]    run_sq_sum;
  logic        [COUNT_W-1:0]  run_len;

  sample_rec_t pending_samples[$];
  stats_rec_t  expected_stats[$];

  int mismatch_count;
  int quiet_cycles;
  int in_gap;
  int out_stall;
  bit no_idle;
  bit in_took;
  bit out_took;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic stats_rec_t predict_stats(sample_rec_t s);
    logic signed [63:0]         diff;
    logic        [63:0]         mag;
    logic signed [SAMPLE_W-1:0] v;
    logic signed [63:0]         wide;
    logic        [SUM_W-1:0]    sq;
    logic        [SUM_W:0]      acc;
    logic        [63:0]         mean;
    logic        [63:0]         root;
    logic        [63:0]         trial;
    stats_rec_t                 r;
    if (cur_mode) begin
      diff = s.a * HEAD_FACTOR - s.b * ROD_FACTOR;
      mag  = (diff < 0) ? -diff : diff;
      mag  = (mag + 64'd32768) >> 16;
      v    = (mag > 64'h7FFF_FFFF) ? S_MAX : mag[SAMPLE_W-1:0];
    end else begin
      v = s.a;
    end
    if (v < cur_min || v > cur_max) v = '0;
    wide = v;
    sq   = wide * wide;
    if (run_len == 0) begin
      run_lo     = v;
      run_hi     = v;
      run_sq_sum = sq;
    end else begin
      if (v < run_lo) run_lo = v;
      if (v > run_hi) run_hi = v;
      acc        = {1'b0, run_sq_sum} + {1'b0, sq};
      run_sq_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    end
    if (run_len < MAX_SAMPLES) run_len = run_len + 1'b1;
    root = '0;
    if (s.last && run_len != 0) begin
      mean = run_sq_sum / 64'(run_len);
      for (int i = 31; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= mean) root = trial;
      end
      if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
    end
    r.value = v;
    r.done  = s.last;
    r.lo    = run_lo;
    r.hi    = run_hi;
    r.rms   = root[RMS_W-1:0];
    r.count = run_len;
    if (s.last) begin
      run_lo     = '0;
      run_hi     = '0;
      run_sq_sum = '0;
      run_len    = '0;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return 32'($urandom_range(0, 2000)) - 32'sd1000;
      4: return 32'($urandom_range(0, 131071)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_sample(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                            logic last);
    pending_samples.push_back('{a: a, b: b, last: last});
  endtask

  task automatic set_range_config(logic m, logic signed [SAMPLE_W-1:0] lo,
                                  logic signed [SAMPLE_W-1:0] hi);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= {{(SAMPLE_W-1){1'b0}}, m};
    @(negedge clk);
    cfg_index <= CFG_MIN;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_MAX;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mode = m;
    cur_min  = lo;
    cur_max  = hi;
  endtask

  task automatic wait_for_drain();
    @(posedge clk);
    while (pending_samples.size() != 0 || in_if.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_took) begin
      // hold the beat until taken
    end else if (in_gap > 0) begin
      in_if.valid <= 1'b0;
      in_gap      <= in_gap - 1;
    end else if (pending_samples.size() != 0) begin
      in_if.valid       <= 1'b1;
      in_if.sample_a    <= pending_samples[0].a;
      in_if.sample_b    <= pending_samples[0].b;
      in_if.last_sample <= pending_samples[0].last;
      pending_samples.delete(0);
      in_gap <= no_idle ? 0 : $urandom_range(0, 5);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // accepted sample beats feed the model
  always @(posedge clk) begin
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready)
      expected_stats.push_back(predict_stats('{a: in_if.sample_a, b: in_if.sample_b,
                                               last: in_if.last_sample}));
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_took) out_stall = no_idle ? 0 : $urandom_range(0, 5);
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_took <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual sample_value %0h",
                 $time, out_if.sample_value);
        mismatch_count++;
      end else begin
        compare_field("sample_value", expected_stats[0].value, out_if.sample_value);
        compare_field("run_done", 32'(expected_stats[0].done), 32'(out_if.run_done));
        compare_field("run_minimum", expected_stats[0].lo, out_if.run_minimum);
        compare_field("run_maximum", expected_stats[0].hi, out_if.run_maximum);
        compare_field("run_rms", 32'(expected_stats[0].rms), 32'(out_if.run_rms));
        compare_field("run_count", 32'(expected_stats[0].count), 32'(out_if.run_count));
        expected_stats.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sensor_range_gate_min_max_rms");
      $finish;
    end
  end

  initial begin
    int                         n;
    int                         len;
    logic                       m;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MODE;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.sample_a    = '0;
    in_if.sample_b    = '0;
    in_if.last_sample = 1'b0;
    out_if.ready      = 1'b0;
    cur_mode          = 1'b0;
    cur_min           = S_MIN;
    cur_max           = S_MAX;
    run_lo            = '0;
    run_hi            = '0;
    run_sq_sum        = '0;
    run_len           = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // plain mode, full range: extremes, rms saturation, square sum saturation
    set_range_config(1'b0, S_MIN, S_MAX);
    add_sample(S_MIN, '0, 1'b1);
    add_sample(S_MAX, S_MIN, 1'b1);
    add_sample('0, S_MAX, 1'b1);
    add_sample(32'sd1, '0, 1'b0);
    add_sample(-32'sd1, '0, 1'b1);
    for (int i = 0; i < 5; i++) add_sample(S_MIN, '0, i == 4);
    wait_for_drain();

    // force mode: saturation, sign of difference, rounding
    set_range_config(1'b1, S_MIN, S_MAX);
    add_sample(S_MAX, S_MIN, 1'b1);
    add_sample(S_MIN, S_MAX, 1'b0);
    add_sample(S_MIN, S_MIN, 1'b0);
    add_sample('0, '0, 1'b1);
    add_sample(32'sd256, 32'sd256, 1'b0);
    add_sample(32'sd1, '0, 1'b1);
    wait_for_drain();

    // inverted range zeroes everything
    set_range_config(1'b0, 32'sd100, -32'sd100);
    add_sample(32'sd5, '0, 1'b0);
    add_sample(S_MIN, '0, 1'b0);
    add_sample(S_MAX, '0, 1'b1);
    wait_for_drain();

    // narrow range: inside, below, above, on the upper bound
    set_range_config(1'b0, -32'sd12800, 32'sd12800);
    add_sample(32'sd300, '0, 1'b0);
    add_sample(-32'sd12801, '0, 1'b0);
    add_sample(32'sd12801, '0, 1'b0);
    add_sample(32'sd12800, '0, 1'b1);
    wait_for_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      m = 1'($urandom_range(0, 1));
      x = $urandom;
      y = $urandom;
      case ($urandom_range(0, 5))
        0: begin lo = S_MIN; hi = S_MAX; end
        1: begin lo = (x < y) ? x : y; hi = (x < y) ? y : x; end
        2: begin
          lo = -$signed(32'($urandom_range(0, 1 << 22)));
          hi = $signed(32'($urandom_range(0, 1 << 22)));
        end
        3: begin lo = (x < y) ? y : x; hi = (x < y) ? x : y; end
        4: begin lo = S_MAX; hi = S_MIN; end
        default: begin lo = S_MIN; hi = $signed(32'($urandom_range(0, 32'h7FFF_FFFF))); end
      endcase
      set_range_config(m, lo, hi);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          add_sample(draw_sample(), draw_sample(), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) add_sample(draw_sample(), draw_sample(), i == len - 1);
          n += len;
        end
      end
      wait_for_drain();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("PASS sensor_range_gate_min_max_rms");
    end else begin
      $display("FAIL sensor_range_gate_min_max_rms");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/srg_pkg.sv
hdl/srg_if.sv
hdl/srg_ctrl.sv
hdl/srg_dp.sv
hdl/sensor_range_gate_min_max_rms.sv
tb/testbench.sv
